// File: rtl/core/sorted_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared concurrent assertion forms, clocked on clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted_priority_queue: assertion failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted_priority_queue: assertion failed");

`endif

// File: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

	localparam int DEF_CAPACITY = 128;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_PEEK   = 2'd2;
	localparam logic [1:0] REQ_NOP    = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] entry_tag;
		logic [15:0] entry_time;
		logic [23:0] entry_price;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] head_tag;
		logic [15:0] head_time;
		logic [23:0] head_price;
		logic [7:0]  fill_count;
	} rsp_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] dep_time;
		logic [23:0] price;
	} entry_t;

	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t item;
	} cell_ctl_t;

endpackage

// File: rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compares the new key, shifts right on
// insert and left on remove.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = $clog2(spq_pkg::DEF_CAPACITY + 1)
) (
	input  logic               clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  logic [CNT_W-1:0]   count,
	input  spq_pkg::entry_t    left_entry,
	input  logic               left_behind,
	input  spq_pkg::entry_t    right_entry,
	output spq_pkg::entry_t    entry,
	output logic               behind
);

	spq_pkg::entry_t entry_q;
	logic            occ;
	logic            tail;
	logic            later;

	assign occ   = CNT_W'(IDX) < count;
	assign tail  = CNT_W'(IDX) == count;
	assign later = (entry_q.dep_time > ctl.item.dep_time) ||
		((entry_q.dep_time == ctl.item.dep_time) && (entry_q.price < ctl.item.price));
	assign behind = occ && later;
	assign entry  = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && (behind || tail)) begin
			entry_q <= left_behind ? left_entry : ctl.item;
		end else if (ctl.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule

// File: rtl/core/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// channel | dir | handshake        | word
// req     | in  | req_valid/stall  | spq_pkg::req_t
// rsp     | out | rsp_valid/stall  | spq_pkg::rsp_t
//
// One request per cycle while req_stall is low; all cells compare in parallel and shift together.
// The response is registered and shows in the cycle after acceptance.
// req_stall is high only while a response waits and rsp_stall holds it.
// Reset empties the queue; slot contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue #(
	parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  spq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output spq_pkg::rsp_t rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_nxt;
	logic [CNT_W+7:0]   count_ext;
	logic               rsp_valid_q;
	spq_pkg::rsp_t      rsp_q;
	spq_pkg::rsp_t      rsp_nxt;
	spq_pkg::cell_ctl_t ctl;
	logic               accept;
	logic               full;
	logic               empty;

	spq_pkg::entry_t cell_entry [CAPACITY];
	logic            cell_behind [CAPACITY];

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = count_q == CNT_W'(CAPACITY);
	assign empty     = count_q == '0;
	assign count_ext = {8'd0, count_nxt};

	always_comb begin
		ctl.ins           = 1'b0;
		ctl.rem           = 1'b0;
		ctl.item.tag      = req.entry_tag;
		ctl.item.dep_time = req.entry_time;
		ctl.item.price    = req.entry_price;
		count_nxt         = count_q;
		rsp_nxt           = '0;
		rsp_nxt.status    = spq_pkg::ST_OK;
		unique case (req.req_type)
			spq_pkg::REQ_INSERT: begin
				if (full) begin
					rsp_nxt.status = spq_pkg::ST_FULL;
				end else begin
					ctl.ins   = accept;
					count_nxt = count_q + 1'b1;
				end
			end
			spq_pkg::REQ_REMOVE, spq_pkg::REQ_PEEK: begin
				if (empty) begin
					rsp_nxt.status = spq_pkg::ST_EMPTY;
				end else begin
					rsp_nxt.head_tag   = cell_entry[0].tag;
					rsp_nxt.head_time  = cell_entry[0].dep_time;
					rsp_nxt.head_price = cell_entry[0].price;
					if (req.req_type == spq_pkg::REQ_REMOVE) begin
						ctl.rem   = accept;
						count_nxt = count_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		rsp_nxt.fill_count = count_ext[7:0];
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_pkg::entry_t left_e;
		spq_pkg::entry_t right_e;
		logic            left_b;
		if (i == 0) begin : g_first
			assign left_e = '0;
			assign left_b = 1'b0;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
			assign left_b = cell_behind[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = cell_entry[i+1];
		end
		spq_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.count       (count_q),
			.left_entry  (left_e),
			.left_behind (left_b),
			.right_entry (right_e),
			.entry       (cell_entry[i]),
			.behind      (cell_behind[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/core/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_priority_queue_macros.svh"

module spq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input spq_pkg::rsp_t rsp
);

	`SPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	`SPQ_ASSERT_NEXT(a_req_gives_rsp, req_valid && !req_stall, rsp_valid)
	`SPQ_ASSERT_NOW(a_err_no_head,
		rsp_valid && (rsp.status != spq_pkg::ST_OK),
		{rsp.head_tag, rsp.head_time, rsp.head_price} == '0)
	`SPQ_ASSERT_NOW(a_empty_count,
		rsp_valid && (rsp.status == spq_pkg::ST_EMPTY),
		rsp.fill_count == '0)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
